// File: rtl/spx_pkg.sv
package spx_pkg;

    // queue between classifier and tile sequencer
    localparam int QueueDepthDefault = 4;

    // stream word widths, padded to whole bytes
    localparam int InDataW  = 56;
    localparam int OutDataW = 40;

    // configuration register indexes
    localparam logic [1:0] CFG_FLIP_SCREEN    = 2'd0;
    localparam logic [1:0] CFG_PRIORITY_MASK  = 2'd1;
    localparam logic [1:0] CFG_PRIORITY_VALUE = 2'd2;

    // positions are measured backwards from this line
    localparam logic signed [9:0] ScreenRef = 10'sd240;
    // entries placed right of this are not drawn
    localparam logic signed [9:0] RightEdge = 10'sd256;

    typedef struct packed {
        logic       flip_screen;
        logic [3:0] priority_mask;
        logic [3:0] priority_value;
    } t_cfg;

    // one classified sprite, ready for tile expansion
    typedef struct packed {
        logic [12:0]       base;
        logic [2:0]        span;
        logic [3:0]        colour;
        logic              mirror_x;
        logic              mirror_y;
        logic              rev;
        logic              step_up;
        logic signed [9:0] x;
        logic signed [9:0] y;
    } t_entry;

endpackage

// File: rtl/sprite_entry_expander.sv
// sprite list entry expander: takes one three-word sprite entry per word on
// the slave stream and emits one tile draw command per 16-pixel tile on the
// master stream, tlast marking the final tile of the sprite. An entry that
// is disabled, fails the priority match, flashes on an odd frame or lies
// off screen to the right is dropped without output. A classifier judges
// each entry in the cycle it is accepted and queues the survivors; a tile
// sequencer drains the queue at one tile per cycle, unless the master side
// stalls, through an output register. Sustained throughput is likewise one
// tile command per cycle while unstalled, dropped entries costing no
// sequencer time; a kept entry yields 1, 2, 4 or 8 tiles. The slave side
// takes a word every cycle while the queue (QueueDepth entries) has room;
// an entry passes the queue, then the output register. Configuration
// writes are always accepted and must be made while the block is idle.
module sprite_entry_expander
    import spx_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave stream: attr_word, code_word, pos_word, frame_odd, zero pad
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    // master stream: tile_code, colour, mirror_x, mirror_y, screen_x,
    // screen_y, zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tlast,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [3:0]          i_cfg_data
);

    t_cfg   r_cfg;
    t_entry entry;
    t_entry head;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    // config registers, writes to unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FLIP_SCREEN:    r_cfg.flip_screen    <= i_cfg_data[0];
                CFG_PRIORITY_MASK:  r_cfg.priority_mask  <= i_cfg_data;
                CFG_PRIORITY_VALUE: r_cfg.priority_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // classify and queue
    spx_front u_front (
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_attr_word (s_tdata[15:0]),
        .i_code_word (s_tdata[31:16]),
        .i_pos_word  (s_tdata[47:32]),
        .i_frame_odd (s_tdata[48]),
        .i_cfg       (r_cfg),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (entry)
    );

    spx_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (head)
    );

    // expand into tiles, one word per cycle while the master side accepts
    spx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule

// File: rtl/spx_front.sv
module spx_front
    import spx_pkg::*;
(
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_attr_word,
    input  logic [15:0] i_code_word,
    input  logic [15:0] i_pos_word,
    input  logic        i_frame_odd,
    input  t_cfg        i_cfg,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic              keep;
    logic [3:0]        colour;
    logic [2:0]        span;
    logic signed [9:0] sx;
    logic signed [9:0] sy;
    logic signed [9:0] x_raw;
    logic signed [9:0] y_raw;

    assign colour = i_pos_word[15:12];
    assign sx     = {i_pos_word[8], i_pos_word[8:0]};
    assign sy     = {i_attr_word[8], i_attr_word[8:0]};
    assign x_raw  = ScreenRef - sx;
    assign y_raw  = ScreenRef - sy;
    assign span   = 3'((4'd1 << i_attr_word[12:11]) - 4'd1);

    // drop disabled, wrong priority, flashing on odd frame, off right edge
    assign keep = i_attr_word[15]
                && ((colour & i_cfg.priority_mask) == i_cfg.priority_value)
                && !(i_pos_word[11] && i_frame_odd)
                && !(x_raw > RightEdge);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && keep;

    always_comb begin
        o_entry.base     = i_code_word[12:0] & ~{10'b0, span};
        o_entry.span     = span;
        o_entry.colour   = colour;
        o_entry.mirror_x = i_attr_word[13] ^ i_cfg.flip_screen;
        o_entry.mirror_y = i_attr_word[14] ^ i_cfg.flip_screen;
        o_entry.rev      = i_attr_word[14];
        o_entry.step_up  = i_cfg.flip_screen;
        o_entry.x        = i_cfg.flip_screen ? (ScreenRef - x_raw) : x_raw;
        o_entry.y        = i_cfg.flip_screen ? (ScreenRef - y_raw) : y_raw;
    end

endmodule

// File: rtl/spx_queue.sv
module spx_queue
    import spx_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_empty,
    input  logic   i_pop,
    output t_entry o_head
);

    localparam int AW = $clog2(Depth);

    t_entry        r_mem [Depth];
    logic [AW:0]   r_wr_ptr;
    logic [AW:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW])
                  && (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_head  = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + (AW+1)'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_entry;
        end
    end

endmodule

// File: rtl/spx_back.sv
module spx_back
    import spx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_entry              i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutDataW-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    logic                r_busy;
    logic                n_busy;
    logic [2:0]          r_k;
    logic [2:0]          n_k;
    t_entry              r_entry;
    t_entry              n_entry;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                r_out_last;

    t_entry            cur;
    logic [2:0]        k;
    logic              emit;
    logic [12:0]       tile;
    logic [9:0]        offs;
    logic signed [9:0] tile_y;

    assign cur  = r_busy ? r_entry : i_head;
    assign k    = r_busy ? r_k : i_head.span;
    assign emit = (r_busy || !i_empty) && (!r_out_valid || i_m_tready);
    assign o_pop = emit && !r_busy;

    // base is aligned to the stack, so or-ing in the offset is an add
    assign tile   = cur.base | {10'b0, (cur.rev ? k : (cur.span ^ k))};
    assign offs   = {3'b000, k, 4'b0000};
    assign tile_y = cur.step_up ? (cur.y + $signed(offs)) : (cur.y - $signed(offs));

    always_comb begin
        n_busy      = r_busy;
        n_k         = r_k;
        n_entry     = r_entry;
        n_out_valid = r_out_valid && !i_m_tready;
        if (emit) begin
            n_out_valid = 1'b1;
            n_entry     = cur;
            if (k == 3'd0) begin
                n_busy = 1'b0;
                n_k    = r_k;
            end else begin
                n_busy = 1'b1;
                n_k    = k - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_entry <= n_entry;
        if (emit) begin
            r_out_data <= {1'b0, tile_y, cur.x, cur.mirror_y, cur.mirror_x,
                           cur.colour, tile};
            r_out_last <= (k == 3'd0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// File: rtl/spx_checker.sv
module spx_checker
    import spx_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic                m_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // tiles of one sprite come back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a sprite's tile burst");

    // colour, mirror bits and x are shared by all tiles of a sprite
    a_same_sprite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            (m_tdata[28:13] == $past(m_tdata[28:13])))
        else $error("sprite attributes changed inside a burst");

    // screen x stays within -16..256
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ($signed(m_tdata[28:19]) >= -10'sd16)
                  && ($signed(m_tdata[28:19]) <= 10'sd256))
        else $error("screen x out of range");

endmodule

bind sprite_entry_expander spx_checker u_spx_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/tb.sv
module tb;
    import spx_pkg::*;

    // run length guard, well above the slowest legal run
    localparam int CycleLimit  = 400000;
    // cycles allowed for a dropped entry to clear the classifier
    localparam int SettleCycles = 8;
    // receiver hold-off used to fill the entry queue
    localparam int HoldCycles  = 300;
    localparam int RandPhases  = 10;
    localparam int PhaseItems  = 30;

    // one sprite list entry as offered on the slave stream
    typedef struct {
        logic [15:0] attr;
        logic [15:0] code;
        logic [15:0] pos;
        logic        odd;
    } t_sprite_entry;

    // one tile draw command, laid out as it is compared
    typedef struct packed {
        logic [12:0]       code;
        logic [3:0]        colour;
        logic              mx;
        logic              my;
        logic signed [9:0] sx;
        logic signed [9:0] sy;
        logic              last;
    } t_tile_cmd;

    typedef struct {
        logic [1:0] idx;
        logic [3:0] data;
    } t_cfg_write;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tlast;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [3:0]          i_cfg_data = '0;

    // entries waiting for the driver, commands waiting for the monitor
    t_sprite_entry entry_q[$];
    t_tile_cmd     tile_q[$];
    t_cfg_write    cfg_q[$];

    // shadow of the block's registers, updated on accepted writes
    logic       pred_flip = 1'b0;
    logic [3:0] pred_mask = '0;
    logic [3:0] pred_value = '0;

    // current phase setting, used to shape random entries
    logic [3:0] ph_mask = '0;
    logic [3:0] ph_value = '0;

    int tx_idle = 0;
    int rx_idle = 0;
    logic hold_start = 1'b0;
    int   hold_left = 0;

    int cycle_cnt = 0;
    int err_cnt = 0;
    int entries_sent = 0;
    int tiles_checked = 0;
    int cfg_writes = 0;

    sprite_entry_expander dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // expand one accepted entry into its tile commands and queue them
    function automatic void expand_entry(logic [15:0] attr, logic [15:0] code,
                                         logic [15:0] pos, logic odd);
        t_tile_cmd t;
        int span;
        int base;
        int x;
        int y;
        int sy;
        int step;
        int tile;
        logic fx;
        logic fy;
        if (!attr[15]) return;
        if ((pos[15:12] & pred_mask) != pred_value) return;
        // flashing sprites vanish on odd frames
        if (pos[11] && odd) return;
        fx = attr[13];
        fy = attr[14];
        span = (1 << attr[12:11]) - 1;
        x = 240 - int'($signed(pos[8:0]));
        y = 240 - int'($signed(attr[8:0]));
        // right edge test comes before the screen flip
        if (x > 256) return;
        base = int'(code[12:0]) & ~span;
        if (pred_flip) begin
            x = 240 - x;
            y = 240 - y;
            fx = ~fx;
            fy = ~fy;
            step = 16;
        end else begin
            step = -16;
        end
        for (int k = span; k >= 0; k--) begin
            sy = y + step * k;
            // tile order along the stack follows the entry's own flip y
            tile = attr[14] ? base + k : base + span - k;
            t.code   = 13'(tile);
            t.colour = pos[15:12];
            t.mx     = fx;
            t.my     = fy;
            t.sx     = 10'(x);
            t.sy     = 10'(sy);
            t.last   = (k == 0);
            tile_q.push_back(t);
        end
    endfunction

    // slave-side driver: one word per accepted entry, random gaps
    always @(posedge i_clk) begin : entry_drv
        t_sprite_entry e;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expand_entry(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[48]);
                entries_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (entry_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
                    e = entry_q.pop_front();
                    // pad, frame_odd, pos_word, code_word, attr_word from the top down
                    s_tdata  <= {7'd0, e.odd, e.pos, e.code, e.attr};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // configuration driver, also keeps the register shadow
    always @(posedge i_clk) begin : cfg_drv
        t_cfg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_FLIP_SCREEN:    pred_flip  <= i_cfg_data[0];
                    CFG_PRIORITY_MASK:  pred_mask  <= i_cfg_data;
                    CFG_PRIORITY_VALUE: pred_value <= i_cfg_data;
                    default: ;
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (cfg_q.size() != 0) begin
                    w = cfg_q.pop_front();
                    i_cfg_index <= w.idx;
                    i_cfg_data  <= w.data;
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HoldCycles;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // master-side ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle);
        end
    end

    // monitor: each accepted word against the oldest expected command
    always @(posedge i_clk) begin : tile_mon
        t_tile_cmd got;
        t_tile_cmd want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[12:0], m_tdata[16:13], m_tdata[17], m_tdata[18],
                   m_tdata[28:19], m_tdata[38:29], m_tlast};
            if (tile_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display({"unexpected tile word: code %h colour %h mx %b my %b",
                              " x %0d y %0d last %b"},
                             got.code, got.colour, got.mx, got.my, got.sx, got.sy,
                             got.last);
            end else begin
                want = tile_q.pop_front();
                tiles_checked++;
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display({"tile mismatch: expected code %h colour %h mx %b",
                                  " my %b x %0d y %0d last %b"},
                                 want.code, want.colour, want.mx, want.my, want.sx,
                                 want.sy, want.last);
                        $display({"               actual   code %h colour %h mx %b",
                                  " my %b x %0d y %0d last %b"},
                                 got.code, got.colour, got.mx, got.my, got.sx,
                                 got.sy, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles, %0d tile commands outstanding",
                     cycle_cnt, tile_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_entry(logic [15:0] attr, logic [15:0] code, logic [15:0] pos,
                             logic odd);
        t_sprite_entry e;
        e.attr = attr;
        e.code = code;
        e.pos  = pos;
        e.odd  = odd;
        entry_q.push_back(e);
    endtask

    task automatic push_cfg(logic [1:0] idx, logic [3:0] data);
        t_cfg_write w;
        w.idx  = idx;
        w.data = data;
        cfg_q.push_back(w);
    endtask

    // all three registers, then wait for the channel to drain
    task automatic set_cfg(logic flip, logic [3:0] mask, logic [3:0] value);
        push_cfg(CFG_FLIP_SCREEN, {3'($urandom), flip});
        push_cfg(CFG_PRIORITY_MASK, mask);
        push_cfg(CFG_PRIORITY_VALUE, value);
        ph_mask  = mask;
        ph_value = value;
        do @(posedge i_clk); while (cfg_q.size() != 0 || i_cfg_valid);
    endtask

    // wait until every expected command is out, then let dropped entries clear
    task automatic drain;
        do @(posedge i_clk);
        while (entry_q.size() != 0 || s_tvalid || tile_q.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // mostly drawable entries with random content, the rest raw noise
    task automatic add_random_entry;
        logic [15:0] attr;
        logic [15:0] code;
        logic [15:0] pos;
        logic        odd;
        int v;
        attr = 16'($urandom);
        code = 16'($urandom);
        pos  = 16'($urandom);
        odd  = 1'($urandom);
        if ($urandom_range(99) < 80) begin
            attr[15] = 1'b1;
            pos[15:12] = (ph_value & ph_mask) | (4'($urandom) & ~ph_mask);
            if (pos[11] && $urandom_range(3) != 0)
                odd = 1'b0;
            if ($urandom_range(4) != 0) begin
                // signed x from -16 to 255, the drawable range
                v = $urandom_range(271);
                pos[8:0] = (v < 256) ? 9'(v) : 9'(v + 240);
            end
        end
        add_entry(attr, code, pos, odd);
    endtask

    initial begin : main
        logic       flip;
        logic [3:0] mask;
        logic [3:0] value;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the first stall mix
        tx_idle = 17;
        rx_idle = 88;

        // plain setting, every register written
        set_cfg(1'b0, 4'h0, 4'h0);
        add_entry(16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);   // disabled
        add_entry(16'h8000, 16'h1FFF, 16'h0000, 1'b0);   // single tile at origin
        add_entry(16'h9800, 16'h1FFF, 16'h0000, 1'b0);   // eight tall, code aligned down
        add_entry(16'hD800, 16'h0005, 16'h0000, 1'b0);   // eight tall, flip y
        add_entry(16'hA800, 16'h0123, 16'h0010, 1'b0);   // two tall, flip x
        add_entry(16'h97FF, 16'hE00A, 16'h06FF, 1'b1);   // unused bits all set
        add_entry(16'h8000, 16'h0001, 16'h0800, 1'b0);   // flashing, even frame
        add_entry(16'h8000, 16'h0002, 16'h0800, 1'b1);   // flashing, odd frame
        add_entry(16'h8000, 16'h0003, 16'h0000, 1'b1);   // odd frame, not flashing
        add_entry(16'h8000, 16'h0004, 16'h01F0, 1'b0);   // right edge, still drawn
        add_entry(16'h8000, 16'h0005, 16'h01EF, 1'b0);   // one past right edge
        add_entry(16'h8000, 16'h0006, 16'h0100, 1'b0);   // far right
        add_entry(16'h8000, 16'h0007, 16'h00FF, 1'b0);   // far left
        add_entry(16'h9900, 16'h0008, 16'hF000, 1'b0);   // y at -256, colour 15
        add_entry(16'hF8FF, 16'h1FF0, 16'h0000, 1'b0);   // y at 255, both flips
        drain();

        // screen flip with an exact priority match
        set_cfg(1'b1, 4'hF, 4'hA);
        add_entry(16'h9900, 16'h1FFF, 16'hA1F0, 1'b0);
        add_entry(16'hD8FF, 16'h0000, 16'hA0FF, 1'b0);
        add_entry(16'hB000, 16'h0AAA, 16'hA100, 1'b0);
        add_entry(16'h8000, 16'h0555, 16'hB000, 1'b0);   // colour fails the match
        drain();

        // value with bits outside the mask draws nothing
        push_cfg(2'd3, 4'hF);                            // index out of range, ignored
        set_cfg(1'b0, 4'h3, 4'h4);
        add_entry(16'h8000, 16'h0011, 16'h4000, 1'b0);
        add_entry(16'h9800, 16'h0022, 16'h0000, 1'b0);
        add_entry(16'h8800, 16'h0033, 16'hC000, 1'b0);
        drain();

        for (int p = 0; p < RandPhases; p++) begin
            if (p < 4) begin
                tx_idle = 17;
                rx_idle = 88;
            end else if (p < 7) begin
                tx_idle = 88;
                rx_idle = 17;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case (p)
                0: set_cfg(1'b0, 4'h0, 4'h0);
                1: set_cfg(1'b1, 4'hF, 4'hF);
                2: set_cfg(1'b0, 4'hF, 4'h0);
                3: set_cfg(1'b1, 4'h0, 4'h0);
                default: begin
                    flip  = 1'($urandom);
                    mask  = 4'($urandom);
                    value = ($urandom_range(4) == 0) ? 4'($urandom) : (mask & 4'($urandom));
                    set_cfg(flip, mask, value);
                end
            endcase
            for (int i = 0; i < PhaseItems; i++)
                add_random_entry();
            // back-pressure: receiver stops while the sender keeps offering
            if (p == 7) begin
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            drain();
        end

        repeat (20) @(posedge i_clk);

        $display("ran %0d sprite entries through %0d register writes across %0d settings",
                 entries_sent, cfg_writes, RandPhases + 3);
        $display("checked %0d tile commands, %0d mismatches", tiles_checked, err_cnt);
        if (err_cnt == 0 && tile_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
